/* hw/rtl/deq_pkg.sv */
// Package for the double-ended queue core: operation codes, default depth
// and the controller-to-datapath command struct. No dependencies.
package deq_pkg;

	localparam int DEFAULT_DEPTH = 1024;
	localparam int WORD_W        = 32;
	localparam int MODE_W        = 3;

	// Operation codes carried on the mode field
	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_PEEK_FRONT = 3'd4;
	localparam logic [MODE_W-1:0] MODE_PEEK_BACK  = 3'd5;
	localparam logic [MODE_W-1:0] MODE_STATUS     = 3'd6;

	// Commands from controller to datapath
	typedef struct packed {
		logic take;   // input transfer this cycle: update pointers, access the store
		logic load;   // move the finished result into the output register
	} deq_cmd_t;

endpackage

/* hw/rtl/deq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/deq_ctrl.sv */
// Controller state machine for the double-ended queue core.
// Depends on deq_pkg for the command struct.
module deq_ctrl
	import deq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	output deq_cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	// Output register can take a new result when empty or being drained
	assign out_free = !out_valid_q || !out_stall;

	assign in_stall = (state_q != ST_IDLE);
	assign cmd.take = in_valid && (state_q == ST_IDLE);
	assign cmd.load = (state_q == ST_DONE) && out_free;
	assign out_valid = out_valid_q;

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (out_valid_q && !out_stall) begin
						out_valid_q <= 1'b0;
					end
					if (in_valid) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* hw/rtl/deq_dpath.sv */
// Datapath for the double-ended queue core: ring pointers, count, entry store
// and output register. Depends on deq_pkg and deq_ram.
module deq_dpath
	import deq_pkg::*;
#(
	parameter int DEPTH = DEFAULT_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  deq_cmd_t                   cmd,
	input  logic [MODE_W-1:0]          mode,
	input  logic signed [WORD_W-1:0]   value,
	output logic signed [WORD_W-1:0]   data_out,
	output logic                       found,
	output logic [$clog2(DEPTH+1)-1:0] occupancy,
	output logic                       is_empty,
	output logic                       overflow
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [PTR_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] count_q;
	logic             found_q, over_q;

	logic [WORD_W-1:0] data_out_q;
	logic              found_out_q, is_empty_q, overflow_q;
	logic [CNT_W-1:0]  occupancy_q;

	logic [PTR_W-1:0] head_next, head_prev, tail_next, tail_prev;
	logic             full, empty;
	logic             ram_we, ram_re;
	logic [PTR_W-1:0] ram_waddr, ram_raddr;
	logic [WORD_W-1:0] ram_rdata;
	logic [PTR_W-1:0] head_d, tail_d;
	logic [CNT_W-1:0] count_d;
	logic             found_d, over_d;

	assign full  = (count_q == CNT_FULL);
	assign empty = (count_q == '0);

	// Ring pointer neighbors
	assign head_next = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
	assign head_prev = (head_q == '0) ? PTR_LAST : head_q - 1'b1;
	assign tail_next = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;
	assign tail_prev = (tail_q == '0) ? PTR_LAST : tail_q - 1'b1;

	// Operation decode
	always_comb begin
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		found_d   = 1'b0;
		over_d    = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = head_prev;
		ram_raddr = head_q;
		unique case (mode)
			MODE_PUSH_FRONT: begin
				if (full) begin
					over_d = 1'b1;
				end else begin
					ram_we  = 1'b1;
					head_d  = head_prev;
					count_d = count_q + 1'b1;
				end
			end
			MODE_PUSH_BACK: begin
				ram_waddr = tail_q;
				if (full) begin
					over_d = 1'b1;
				end else begin
					ram_we  = 1'b1;
					tail_d  = tail_next;
					count_d = count_q + 1'b1;
				end
			end
			MODE_POP_FRONT: begin
				if (!empty) begin
					ram_re  = 1'b1;
					found_d = 1'b1;
					head_d  = head_next;
					count_d = count_q - 1'b1;
				end
			end
			MODE_POP_BACK: begin
				ram_raddr = tail_prev;
				if (!empty) begin
					ram_re  = 1'b1;
					found_d = 1'b1;
					tail_d  = tail_prev;
					count_d = count_q - 1'b1;
				end
			end
			MODE_PEEK_FRONT: begin
				if (!empty) begin
					ram_re  = 1'b1;
					found_d = 1'b1;
				end
			end
			MODE_PEEK_BACK: begin
				ram_raddr = tail_prev;
				if (!empty) begin
					ram_re  = 1'b1;
					found_d = 1'b1;
				end
			end
			default: begin
				// status only, and the unused code
			end
		endcase
	end

	// Entry store
	deq_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.take && ram_we),
		.waddr(ram_waddr),
		.wdata(value),
		.re   (cmd.take && ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Pointers, count and per-item flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			found_q <= 1'b0;
			over_q  <= 1'b0;
		end else if (cmd.take) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			found_q <= found_d;
			over_q  <= over_d;
		end
	end

	// Output register, read data arrives the cycle after the transfer
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			data_out_q  <= found_q ? ram_rdata : '0;
			found_out_q <= found_q;
			occupancy_q <= count_q;
			is_empty_q  <= empty;
			overflow_q  <= over_q;
		end
	end

	assign data_out  = data_out_q;
	assign found     = found_out_q;
	assign occupancy = occupancy_q;
	assign is_empty  = is_empty_q;
	assign overflow  = overflow_q;

endmodule

/* hw/rtl/double_ended_queue_core.sv */
// Double-ended queue core over a ring store of DEPTH signed words.
// Result path: the store read and the per-item flags are registered at the input transfer,
// then the output register is loaded from them once it is free (empty or being drained).
// Inputs: a new item is not taken until the previous result has been loaded; the next
// input is taken while a finished result still waits in the output register.
// Reset: pointers, count and valid cleared at once; the store is not cleared.
module double_ended_queue_core
	import deq_pkg::*;
#(
	parameter int DEPTH = DEFAULT_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [MODE_W-1:0]          mode,
	input  logic signed [WORD_W-1:0]   value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [WORD_W-1:0]   data_out,
	output logic                       found,
	output logic [$clog2(DEPTH+1)-1:0] occupancy,
	output logic                       is_empty,
	output logic                       overflow
);

	deq_cmd_t cmd;

	// Controller
	deq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd)
	);

	// Datapath
	deq_dpath #(
		.DEPTH(DEPTH)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.mode     (mode),
		.value    (value),
		.data_out (data_out),
		.found    (found),
		.occupancy(occupancy),
		.is_empty (is_empty),
		.overflow (overflow)
	);

	// A transfer always leaves the block busy in the next cycle
	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after transfer");

	// A dropped push only happens on a full store
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> (occupancy == ($clog2(DEPTH+1))'(DEPTH)) && !found)
		else $error("overflow without full store");

	// Count never exceeds the store depth
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> occupancy <= ($clog2(DEPTH+1))'(DEPTH))
		else $error("occupancy beyond depth");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for double_ended_queue_core: scoreboard class with a deque predictor,
// directed corner cases and random mixed traffic.
// Depends on deq_pkg and the core RTL only.
module tb_top;
	import deq_pkg::*;

	localparam int DEPTH       = DEFAULT_DEPTH;
	localparam int OCC_W       = $clog2(DEPTH + 1);
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RAND_ITEMS  = 726;
	localparam int SEG_LEN     = 50;
	// mode code 7 has no operation; the core treats it as status
	localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

	typedef struct packed {
		logic signed [WORD_W-1:0] data;
		logic                     hit;
		logic [OCC_W-1:0]         occ;
		logic                     empty;
		logic                     ovf;
	} deq_result_t;

	// Deque predictor plus the queue of results still awaited
	class deque_scoreboard;
		logic signed [WORD_W-1:0] slot_mem [DEPTH];
		int unsigned head_idx;
		int unsigned tail_idx;
		int unsigned entries;
		deq_result_t awaited_q[$];
		int unsigned error_count;
		int unsigned result_count;
		int unsigned drop_count;
		int unsigned peak_entries;

		function new();
			head_idx = 0;
			tail_idx = 0;
			entries = 0;
			error_count = 0;
			result_count = 0;
			drop_count = 0;
			peak_entries = 0;
		endfunction

		function int unsigned pending();
			return awaited_q.size();
		endfunction

		function int unsigned level();
			return entries;
		endfunction

		// Apply one accepted operation and queue the result it must produce
		function void note_input(logic [MODE_W-1:0] op, logic signed [WORD_W-1:0] word);
			deq_result_t r;
			bit full;
			bit empty;
			r = '0;
			full = entries >= DEPTH;
			empty = entries == 0;
			case (op)
				MODE_PUSH_FRONT: begin
					if (full) begin
						r.ovf = 1'b1;
					end else begin
						head_idx = (head_idx == 0) ? DEPTH - 1 : head_idx - 1;
						slot_mem[head_idx] = word;
						entries++;
					end
				end
				MODE_PUSH_BACK: begin
					if (full) begin
						r.ovf = 1'b1;
					end else begin
						slot_mem[tail_idx] = word;
						tail_idx = (tail_idx + 1 >= DEPTH) ? 0 : tail_idx + 1;
						entries++;
					end
				end
				MODE_POP_FRONT: begin
					if (!empty) begin
						r.data = slot_mem[head_idx];
						r.hit = 1'b1;
						head_idx = (head_idx + 1 >= DEPTH) ? 0 : head_idx + 1;
						entries--;
					end
				end
				MODE_POP_BACK: begin
					if (!empty) begin
						tail_idx = (tail_idx == 0) ? DEPTH - 1 : tail_idx - 1;
						r.data = slot_mem[tail_idx];
						r.hit = 1'b1;
						entries--;
					end
				end
				MODE_PEEK_FRONT: begin
					if (!empty) begin
						r.data = slot_mem[head_idx];
						r.hit = 1'b1;
					end
				end
				MODE_PEEK_BACK: begin
					if (!empty) begin
						r.data = slot_mem[(tail_idx == 0) ? DEPTH - 1 : tail_idx - 1];
						r.hit = 1'b1;
					end
				end
				default: begin
					// status and the unused code change nothing
				end
			endcase
			r.occ = entries[OCC_W-1:0];
			r.empty = (entries == 0);
			if (r.ovf)
				drop_count++;
			if (entries > peak_entries)
				peak_entries = entries;
			awaited_q = {awaited_q, r};
		endfunction

		task report_error(string msg);
			error_count++;
			if (error_count <= 40)
				$display("%0t MISMATCH: %s", $time, msg);
		endtask

		// Compare one output transfer with the oldest awaited result
		task check_result(deq_result_t got);
			deq_result_t exp;
			result_count++;
			if (awaited_q.size() == 0) begin
				report_error("output transfer with nothing awaited");
				return;
			end
			exp = awaited_q[0];
			awaited_q.delete(0);
			if (got.data !== exp.data)
				report_error($sformatf("data_out got %0d exp %0d", got.data, exp.data));
			if (got.hit !== exp.hit)
				report_error($sformatf("found got %b exp %b", got.hit, exp.hit));
			if (got.occ !== exp.occ)
				report_error($sformatf("occupancy got %0d exp %0d", got.occ, exp.occ));
			if (got.empty !== exp.empty)
				report_error($sformatf("is_empty got %b exp %b", got.empty, exp.empty));
			if (got.ovf !== exp.ovf)
				report_error($sformatf("overflow got %b exp %b", got.ovf, exp.ovf));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [MODE_W-1:0] mode;
	logic signed [WORD_W-1:0] value;
	logic out_valid;
	logic out_stall;
	logic signed [WORD_W-1:0] data_out;
	logic found;
	logic [OCC_W-1:0] occupancy;
	logic is_empty;
	logic overflow;

	deque_scoreboard sb;
	bit quiet;
	int unsigned cycle_count;
	int unsigned sent_count;

	double_ended_queue_core #(
		.DEPTH(DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.value    (value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.data_out (data_out),
		.found    (found),
		.occupancy(occupancy),
		.is_empty (is_empty),
		.overflow (overflow)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Mostly short gaps, a few long ones, none in quiet stretches
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	function automatic logic signed [WORD_W-1:0] rand_word();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	// One input transfer, then an optional gap with valid low
	task send_item(logic [MODE_W-1:0] op, logic signed [WORD_W-1:0] word);
		int unsigned gap;
		in_valid <= 1'b1;
		mode <= op;
		value <= word;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_input(op, word);
		sent_count++;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			mode <= MODE_W'($urandom);
			value <= $urandom;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold off the sender until every awaited result has come back
	task drain_results();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task send_random_op(int unsigned push_pct);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < push_pct) begin
			send_item($urandom_range(0, 1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT, rand_word());
		end else begin
			r = $urandom_range(0, 99);
			if (r < 60)
				send_item($urandom_range(0, 1) ? MODE_POP_BACK : MODE_POP_FRONT, $urandom);
			else if (r < 88)
				send_item($urandom_range(0, 1) ? MODE_PEEK_BACK : MODE_PEEK_FRONT, $urandom);
			else if (r < 96)
				send_item(MODE_STATUS, $urandom);
			else
				send_item(MODE_UNUSED, $urandom);
		end
	endtask

	// Output side: random stall runs
	initial begin
		int unsigned stall_len;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall_len = pick_gap();
			if (stall_len > 0) begin
				out_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
				out_stall <= 1'b0;
			end
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	end

	// Output monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{data_out, found, occupancy, is_empty, overflow});
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("timeout after %0d cycles", cycle_count);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		int unsigned push_pct;
		sb = new();
		quiet = 1'b0;
		cycle_count = 0;
		sent_count = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		mode <= MODE_STATUS;
		value <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-queue reads, head wrap below slot zero, word extremes
		send_item(MODE_STATUS, '0);
		send_item(MODE_POP_FRONT, '0);
		send_item(MODE_POP_BACK, '1);
		send_item(MODE_PEEK_FRONT, '0);
		send_item(MODE_PEEK_BACK, '0);
		send_item(MODE_UNUSED, '1);
		send_item(MODE_PUSH_FRONT, 32'sh7FFF_FFFF);
		send_item(MODE_PUSH_BACK, 32'sh8000_0000);
		send_item(MODE_PUSH_FRONT, '1);
		send_item(MODE_PUSH_BACK, '0);
		send_item(MODE_PEEK_FRONT, '0);
		send_item(MODE_PEEK_BACK, '0);
		send_item(MODE_POP_BACK, '0);
		send_item(MODE_POP_FRONT, '0);
		send_item(MODE_PUSH_BACK, 32'sh5555_5555);
		send_item(MODE_PUSH_FRONT, 32'shAAAA_AAAA);
		send_item(MODE_STATUS, '1);
		send_item(MODE_UNUSED, 32'sh1234_5678);
		send_item(MODE_POP_FRONT, '0);
		send_item(MODE_POP_FRONT, '0);
		send_item(MODE_POP_FRONT, '0);
		send_item(MODE_POP_BACK, '0);
		send_item(MODE_POP_BACK, '0);
		send_item(MODE_PEEK_BACK, '0);
		drain_results();

		// Random mixed traffic in segments with differing push bias
		push_pct = 50;
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i % SEG_LEN == 0) begin
				case ($urandom_range(0, 2))
					0: push_pct = 25;
					1: push_pct = 50;
					default: push_pct = 75;
				endcase
				quiet = ($urandom_range(0, 3) == 0);
				if ($urandom_range(0, 4) == 0)
					drain_results();
			end
			send_random_op(push_pct);
		end
		quiet = 1'b0;

		// Wait out the remaining results plus the pipeline latency
		drain_results();
		repeat (10) @(posedge clk);

		$display("Sent %0d operations, checked %0d results, cycles %0d.",
			sent_count, sb.result_count, cycle_count);
		$display("Pushes dropped on a full store: %0d, peak occupancy %0d of %0d.",
			sb.drop_count, sb.peak_entries, DEPTH);
		if (sb.error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", sb.error_count);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
